// File: rtl/core/swfr_pkg.sv
// Shared types, constants and the arctangent table for the steered wheel force rotation.
// Every module of the block imports this package; it depends on nothing else.
`timescale 1ns / 1ps

package swfr_pkg;

    // Number of rotation iterations; the table only goes to 24 entries.
    localparam int ROTATION_STAGES     = 16;
    localparam int ANGLE_FRACTION_BITS = 13;
    localparam int NSTG = (ROTATION_STAGES > 24) ? 24 : ROTATION_STAGES;

    localparam int ANG_W     = 16;
    localparam int FORCE_W   = 24;
    localparam int WORK_FRAC = 30;
    localparam int GAIN_W    = 31;
    localparam int PROD_W    = FORCE_W + GAIN_W;
    localparam int VW        = 56;
    localparam int ZIN_W     = ANG_W + WORK_FRAC - ANGLE_FRACTION_BITS;
    localparam int ZW1       = ZIN_W + 1;
    localparam int ZC_W      = 33;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint FORCE_MAX   = 64'sd8388607;
    localparam longint FORCE_MIN   = -64'sd8388608;

    // Largest number of quarter turns that a widened angle can hold.
    localparam int NQT = int'(((64'sd1 <<< (ZIN_W - 1)) - 64'sd1) / HALF_PI_Q30);
    localparam int KW  = ($clog2(NQT + 1) > 2) ? $clog2(NQT + 1) : 2;

    // Quarter-turn stages, rotation stages and the output register.
    localparam int LATENCY = NSTG + 3;

    typedef logic signed [ANG_W-1:0]   t_angle;
    typedef logic signed [FORCE_W-1:0] t_force;
    typedef logic signed [GAIN_W-1:0]  t_gain;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [VW-1:0]      t_vec;
    typedef logic signed [ZIN_W-1:0]   t_zin;
    typedef logic signed [ZW1-1:0]     t_zwide;
    typedef logic signed [ZC_W-1:0]    t_zc;

    typedef struct packed {
        t_angle angle;
        t_force fx;
        t_force fy;
    } t_front_in;

    typedef struct packed {
        t_vec x;
        t_vec y;
        t_zc  z;
    } t_lane;

    typedef struct packed {
        t_force x;
        t_force y;
    } t_front_out;

    typedef struct packed {
        t_force rl_x;
        t_force rl_y;
        t_force rr_x;
        t_force rr_y;
    } t_rear;

    typedef t_front_in  [1:0] t_front_in_pair;
    typedef t_lane      [1:0] t_lane_pair;
    typedef t_front_out [1:0] t_front_out_pair;

    // atan(2^-i) in Q30, rounded to nearest.
    function automatic longint atan_q30(input int i);
        longint v;
        unique case (i)
            0:       v = 64'sd843314857;
            1:       v = 64'sd497837829;
            2:       v = 64'sd263043837;
            3:       v = 64'sd133525159;
            4:       v = 64'sd67021687;
            5:       v = 64'sd33543516;
            6:       v = 64'sd16775851;
            7:       v = 64'sd8388437;
            8:       v = 64'sd4194283;
            9:       v = 64'sd2097149;
            10:      v = 64'sd1048576;
            11:      v = 64'sd524288;
            12:      v = 64'sd262144;
            13:      v = 64'sd131072;
            14:      v = 64'sd65536;
            15:      v = 64'sd32768;
            16:      v = 64'sd16384;
            17:      v = 64'sd8192;
            18:      v = 64'sd4096;
            19:      v = 64'sd2048;
            20:      v = 64'sd1024;
            21:      v = 64'sd512;
            22:      v = 64'sd256;
            23:      v = 64'sd128;
            default: v = 64'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/swfr_prerot.sv
// Front end of the rotation: gain multiply, angle widening and exact quarter turns.
// Two register stages; depends on swfr_pkg.
`timescale 1ns / 1ps

module swfr_prerot (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  swfr_pkg::t_front_in_pair i_front,
    output logic                  o_valid,
    output swfr_pkg::t_lane_pair  o_lanes
);
    import swfr_pkg::*;

    localparam int          ZPAD   = WORK_FRAC - ANGLE_FRACTION_BITS;
    localparam t_gain       GAIN_C = GAIN_W'(GAIN_Q30);
    localparam logic [1:0]  QT_0   = 2'd0;
    localparam logic [1:0]  QT_90  = 2'd1;
    localparam logic [1:0]  QT_180 = 2'd2;
    localparam logic [1:0]  QT_270 = 2'd3;

    t_prod      n_px [2];
    t_prod      n_py [2];
    t_zc        n_zr [2];
    logic [1:0] n_q  [2];

    logic       r_v1;
    t_prod      r_px [2];
    t_prod      r_py [2];
    t_zc        r_zr [2];
    logic [1:0] r_q  [2];

    t_lane      n_lane [2];
    logic       r_v2;
    t_lane_pair r_lanes;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        t_zin       z_in;
        t_zwide     z_ext;
        t_zwide     thr;
        t_zwide     off;
        t_zwide     z_red;
        logic [KW-1:0] k;
        t_vec       xe;
        t_vec       ye;

        assign z_in  = {i_front[l].angle, {ZPAD{1'b0}}};
        assign z_ext = ZW1'(z_in);

        // Count the quarter turns that bring the angle into [-pi/2, pi/2].
        always_comb begin
            k   = '0;
            off = '0;
            thr = '0;
            for (int m = 1; m <= NQT; m++) begin
                thr = ZW1'(longint'(m) * HALF_PI_Q30);
                if (z_ext > thr) begin
                    k   = KW'(m);
                    off = thr;
                end else if (z_ext < -thr) begin
                    k   = KW'(m);
                    off = -thr;
                end
            end
            z_red   = z_ext - off;
            n_zr[l] = ZC_W'(z_red);
            n_q[l]  = z_ext[ZW1-1] ? (2'b00 - k[1:0]) : k[1:0];
            n_px[l] = t_prod'(i_front[l].fx) * t_prod'(GAIN_C);
            n_py[l] = t_prod'(i_front[l].fy) * t_prod'(GAIN_C);
        end

        assign xe = VW'(r_px[l]);
        assign ye = VW'(r_py[l]);

        always_comb begin
            n_lane[l].z = r_zr[l];
            unique case (r_q[l])
                QT_0: begin
                    n_lane[l].x = xe;
                    n_lane[l].y = ye;
                end
                QT_90: begin
                    n_lane[l].x = -ye;
                    n_lane[l].y = xe;
                end
                QT_180: begin
                    n_lane[l].x = -xe;
                    n_lane[l].y = -ye;
                end
                QT_270: begin
                    n_lane[l].x = ye;
                    n_lane[l].y = -xe;
                end
                default: begin
                    n_lane[l].x = xe;
                    n_lane[l].y = ye;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r_px[l]    <= n_px[l];
            r_py[l]    <= n_py[l];
            r_zr[l]    <= n_zr[l];
            r_q[l]     <= n_q[l];
            r_lanes[l] <= n_lane[l];
        end
    end

    assign o_valid = r_v2;
    assign o_lanes = r_lanes;

endmodule

// File: rtl/core/swfr_cordic.sv
// Unrolled rotation pipeline: one shift-add iteration per register stage, two lanes.
// Depends on swfr_pkg for widths, stage count and the arctangent table.
`timescale 1ns / 1ps

module swfr_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  swfr_pkg::t_lane_pair i_lanes,
    output logic                 o_valid,
    output swfr_pkg::t_lane_pair o_lanes
);
    import swfr_pkg::*;

    t_lane_pair r_st  [NSTG];
    logic       r_vld [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam t_zc ATAN = ZC_W'(atan_q30(s));
        t_lane_pair src;
        t_lane_pair n_st;
        logic       src_v;
        t_vec       xs [2];
        t_vec       ys [2];

        if (s == 0) begin : g_first
            assign src   = i_lanes;
            assign src_v = i_valid;
        end else begin : g_next
            assign src   = r_st[s-1];
            assign src_v = r_vld[s-1];
        end

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                xs[l] = src[l].x >>> s;
                ys[l] = src[l].y >>> s;
                if (!src[l].z[ZC_W-1]) begin
                    n_st[l].x = src[l].x - ys[l];
                    n_st[l].y = src[l].y + xs[l];
                    n_st[l].z = src[l].z - ATAN;
                end else begin
                    n_st[l].x = src[l].x + ys[l];
                    n_st[l].y = src[l].y - xs[l];
                    n_st[l].z = src[l].z + ATAN;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_st[s] <= n_st;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= src_v;
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_lanes = r_st[NSTG-1];

endmodule

// File: rtl/core/swfr_post.sv
// Output stage: round the Q30 working values to whole units and saturate to 24 bits.
// One register stage; depends on swfr_pkg.
`timescale 1ns / 1ps

module swfr_post (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  swfr_pkg::t_lane_pair      i_lanes,
    output logic                      o_valid,
    output swfr_pkg::t_front_out_pair o_forces
);
    import swfr_pkg::*;

    localparam t_vec RND    = VW'(64'sd1 <<< (WORK_FRAC - 1));
    localparam t_vec SAT_HI = VW'(FORCE_MAX);
    localparam t_vec SAT_LO = VW'(FORCE_MIN);

    t_vec            sx [2];
    t_vec            sy [2];
    t_front_out_pair n_out;
    t_front_out_pair r_out;
    logic            r_valid;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sx[l] = (i_lanes[l].x + RND) >>> WORK_FRAC;
            sy[l] = (i_lanes[l].y + RND) >>> WORK_FRAC;
            if (sx[l] > SAT_HI) begin
                n_out[l].x = FORCE_W'(SAT_HI);
            end else if (sx[l] < SAT_LO) begin
                n_out[l].x = FORCE_W'(SAT_LO);
            end else begin
                n_out[l].x = FORCE_W'(sx[l]);
            end
            if (sy[l] > SAT_HI) begin
                n_out[l].y = FORCE_W'(SAT_HI);
            end else if (sy[l] < SAT_LO) begin
                n_out[l].y = FORCE_W'(SAT_LO);
            end else begin
                n_out[l].y = FORCE_W'(sy[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid  = r_valid;
    assign o_forces = r_out;

endmodule

// File: rtl/core/steered_wheel_force_rotation_top.sv
// Top level of the steered wheel force rotation block.
// Instantiates swfr_prerot, swfr_cordic and swfr_post; depends on swfr_pkg.
`timescale 1ns / 1ps

// How to use this block.
// An item is the two front steering angles and the longitudinal and lateral forces of
// all four wheels. It is taken at a rising clock edge at which start is high and busy
// is low. Busy is always low: the block is a fully pipelined datapath, so a new item
// may be offered in every clock cycle and the sustained rate is one item per cycle.
// Each front force pair is rotated into the body frame by its steering angle through
// a gain-compensated shift-add rotation; the rear forces are carried unchanged along
// a delay line of the same length.
// The result of an item is on the o_body_* ports for exactly one cycle, marked by
// o_valid. An item passes the gain multiply and quarter turns, then each of the
// sixteen rotation stages, then rounding and saturation. Results leave in the order
// in which the items came in.
// The receiver cannot hold results off, so nothing in the pipeline ever waits.
// A synchronous reset (i_rst_n low) clears every valid bit at once; items in flight
// are dropped and no result strobe appears until a new item has gone through.
module steered_wheel_force_rotation_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  swfr_pkg::t_angle i_left_steer_angle,
    input  swfr_pkg::t_angle i_right_steer_angle,
    input  swfr_pkg::t_force i_front_left_long_force,
    input  swfr_pkg::t_force i_front_left_lat_force,
    input  swfr_pkg::t_force i_front_right_long_force,
    input  swfr_pkg::t_force i_front_right_lat_force,
    input  swfr_pkg::t_force i_rear_left_long_force,
    input  swfr_pkg::t_force i_rear_left_lat_force,
    input  swfr_pkg::t_force i_rear_right_long_force,
    input  swfr_pkg::t_force i_rear_right_lat_force,
    output logic            o_valid,
    output swfr_pkg::t_force o_body_fl_x,
    output swfr_pkg::t_force o_body_fl_y,
    output swfr_pkg::t_force o_body_fr_x,
    output swfr_pkg::t_force o_body_fr_y,
    output swfr_pkg::t_force o_body_rl_x,
    output swfr_pkg::t_force o_body_rl_y,
    output swfr_pkg::t_force o_body_rr_x,
    output swfr_pkg::t_force o_body_rr_y
);
    import swfr_pkg::*;

    logic            accept;
    t_front_in_pair  front_in;
    logic            pre_valid;
    t_lane_pair      pre_lanes;
    logic            rot_valid;
    t_lane_pair      rot_lanes;
    t_front_out_pair front_out;
    t_rear           rear_in;
    t_rear           r_rear [LATENCY];

    // The pipeline never stalls, so every start is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Lane 0 is the front left wheel, lane 1 the front right wheel.
    assign front_in[0].angle = i_left_steer_angle;
    assign front_in[0].fx    = i_front_left_long_force;
    assign front_in[0].fy    = i_front_left_lat_force;
    assign front_in[1].angle = i_right_steer_angle;
    assign front_in[1].fx    = i_front_right_long_force;
    assign front_in[1].fy    = i_front_right_lat_force;

    swfr_prerot u_prerot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_front (front_in),
        .o_valid (pre_valid),
        .o_lanes (pre_lanes)
    );

    swfr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pre_valid),
        .i_lanes (pre_lanes),
        .o_valid (rot_valid),
        .o_lanes (rot_lanes)
    );

    swfr_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rot_valid),
        .i_lanes  (rot_lanes),
        .o_valid  (o_valid),
        .o_forces (front_out)
    );

    // The rear forces need no arithmetic; they only travel alongside the front lanes so
    // that both halves of a result leave in the same cycle.
    assign rear_in.rl_x = i_rear_left_long_force;
    assign rear_in.rl_y = i_rear_left_lat_force;
    assign rear_in.rr_x = i_rear_right_long_force;
    assign rear_in.rr_y = i_rear_right_lat_force;

    always_ff @(posedge i_clk) begin
        r_rear[0] <= rear_in;
        for (int i = 1; i < LATENCY; i++) begin
            r_rear[i] <= r_rear[i-1];
        end
    end

    assign o_body_fl_x = front_out[0].x;
    assign o_body_fl_y = front_out[0].y;
    assign o_body_fr_x = front_out[1].x;
    assign o_body_fr_y = front_out[1].y;
    assign o_body_rl_x = r_rear[LATENCY-1].rl_x;
    assign o_body_rl_y = r_rear[LATENCY-1].rl_y;
    assign o_body_rr_x = r_rear[LATENCY-1].rr_x;
    assign o_body_rr_y = r_rear[LATENCY-1].rr_y;

endmodule

// File: rtl/core/swfr_checker.sv
// Port-level checks for the steered wheel force rotation top level, attached by bind.
// Depends on swfr_pkg for the pipeline latency.
`timescale 1ns / 1ps

module swfr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input swfr_pkg::t_force i_rear_left_long_force,
    input swfr_pkg::t_force i_rear_right_lat_force,
    input logic             o_valid,
    input swfr_pkg::t_force o_body_rl_x,
    input swfr_pkg::t_force o_body_rr_y
);
    import swfr_pkg::*;

    // A reset cycle leaves no result strobe behind it.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe directly after reset");

    // Every item taken gives its result after exactly the pipeline latency.
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("item taken but no result after the pipeline latency");

    // No result appears without an item taken that far back.
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result strobe without a matching item");

    // The rear forces of a result belong to the same item as its front forces.
    a_rear_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_body_rl_x == $past(i_rear_left_long_force, LATENCY))
                 && (o_body_rr_y == $past(i_rear_right_lat_force, LATENCY)))
        else $error("rear forces out of step with the result");

endmodule

bind steered_wheel_force_rotation_top swfr_checker u_swfr_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .start                  (start),
    .busy                   (busy),
    .i_rear_left_long_force (i_rear_left_long_force),
    .i_rear_right_lat_force (i_rear_right_lat_force),
    .o_valid                (o_valid),
    .o_body_rl_x            (o_body_rl_x),
    .o_body_rr_y            (o_body_rr_y)
);
